>>> rtl/core/pcl_pkg.sv
// ----------------------------------------------------------------------------
// pcl_pkg
// Operation and status codes shared by the positional circular list files.
// ----------------------------------------------------------------------------
package pcl_pkg;

   typedef enum logic [2:0] {
      K_INS_FRONT = 3'd0,
      K_INS_BACK  = 3'd1,
      K_INS_AT    = 3'd2,
      K_DEL_FRONT = 3'd3,
      K_DEL_BACK  = 3'd4,
      K_DEL_AT    = 3'd5,
      K_READ_AT   = 3'd6
   } kind_type;

   typedef enum logic [1:0] {
      ST_DONE   = 2'd0,
      ST_BADPOS = 2'd1,
      ST_FULL   = 2'd2,
      ST_EMPTY  = 2'd3
   } status_type;

   localparam int unsigned VALUE_W = 32;
   localparam int unsigned POS_W   = 7;
   localparam int unsigned COUNT_W = 7;

endpackage

>>> rtl/core/positional_circular_list_top.sv
// ----------------------------------------------------------------------------
// positional_circular_list_top
// Bounded ordered list of signed 32-bit values kept as a circular chain of
// slots in a value memory and a link memory.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one operation word: req_tuser is the kind, req_tdata
//   holds the value and the 1-based position. rsp channel returns one word
//   per request: rsp_tuser is the status, rsp_tdata the element count after
//   the operation and the value read by a read at position.
//   One request is worked on at a time. A request that fails its checks
//   goes straight to its response word; an insert or delete at the front
//   needs no walk, while an insert further back, a delete or a read walks
//   the link memory from the head towards the position, and an insert
//   that reuses a freed slot first takes it off the free chain. The next
//   request is taken in the cycle the response word appears.
//   The walk follows one link per cycle through the single registered
//   read port of the link memory.
//   Reset empties the list at once; memory contents are not cleared.
//   A finished word waits in the output register while rsp_tready is low;
//   a new request is taken meanwhile and holds at its end until the output
//   register is free.
// ----------------------------------------------------------------------------
module positional_circular_list_top #(
   parameter int unsigned CAPACITY = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  pcl_pkg::kind_type      req_tuser,   // kind
   input  logic [39:0]            req_tdata,   // value[31:0], position[38:32]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output pcl_pkg::status_type    rsp_tuser,   // status
   output logic [39:0]            rsp_tdata    // count[6:0], read_value[38:7]
);
   import pcl_pkg::*;

   localparam int unsigned IW = $clog2(CAPACITY);
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned PW = (CW + 1 > 8) ? CW + 1 : 8;

   typedef enum logic [12:0] {
      S_IDLE   = 13'b0000000000001,
      S_CHECK  = 13'b0000000000010,
      S_TAKE   = 13'b0000000000100,
      S_PLACE  = 13'b0000000001000,
      S_FIX    = 13'b0000000010000,
      S_LOCATE = 13'b0000000100000,
      S_WALK   = 13'b0000001000000,
      S_LINK   = 13'b0000010000000,
      S_RVAL   = 13'b0000100000000,
      S_DHEAD  = 13'b0001000000000,
      S_DLINK  = 13'b0010000000000,
      S_FREE   = 13'b0100000000000,
      S_DONE   = 13'b1000000000000
   } state_type;

   state_type            state_ff, state_in;
   kind_type             kind_ff, kind_in;
   logic [VALUE_W-1:0]   value_ff, value_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [IW-1:0]        head_ff, head_in;
   logic [IW-1:0]        tail_ff, tail_in;
   logic [IW-1:0]        free_ff, free_in;
   logic [IW-1:0]        slot_ff, slot_in;
   logic [IW-1:0]        cur_ff, cur_in;
   logic [IW-1:0]        victim_ff, victim_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        fresh_ff, fresh_in;
   logic [PW-1:0]        steps_ff, steps_in;
   logic                 first_ff, first_in;
   logic                 end_ff, end_in;
   status_type           status_ff, status_in;
   logic [VALUE_W-1:0]   rdval_ff, rdval_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic [VALUE_W-1:0]   rsp_read_ff, rsp_read_in;

   logic [VALUE_W-1:0]   value_mem [CAPACITY];
   logic [IW-1:0]        link_mem  [CAPACITY];
   logic [VALUE_W-1:0]   value_rd_ff;
   logic [IW-1:0]        link_rd_ff;

   logic                 value_we, value_re;
   logic [IW-1:0]        value_waddr, value_raddr;
   logic                 link_we, link_re;
   logic [IW-1:0]        link_waddr, link_wdata, link_raddr;

   logic                 is_ins, is_del, is_rd;
   logic [PW-1:0]        p_eff, cnt_p;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {1'b0, rsp_read_ff, rsp_count_ff};

   assign is_ins = kind_ff inside {K_INS_FRONT, K_INS_BACK, K_INS_AT};
   assign is_del = kind_ff inside {K_DEL_FRONT, K_DEL_BACK, K_DEL_AT};
   assign is_rd  = (kind_ff == K_READ_AT);
   assign cnt_p  = PW'(count_ff);

   always_comb begin
      case (kind_ff)
         K_INS_FRONT, K_DEL_FRONT: p_eff = PW'(1);
         K_INS_BACK:               p_eff = cnt_p + PW'(1);
         K_DEL_BACK:               p_eff = cnt_p;
         default:                  p_eff = PW'(pos_ff);
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      value_in      = value_ff;
      pos_in        = pos_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      free_in       = free_ff;
      slot_in       = slot_ff;
      cur_in        = cur_ff;
      victim_in     = victim_ff;
      count_in      = count_ff;
      fresh_in      = fresh_ff;
      steps_in      = steps_ff;
      first_in      = first_ff;
      end_in        = end_ff;
      status_in     = status_ff;
      rdval_in      = rdval_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_read_in   = rsp_read_ff;
      value_we      = 1'b0;
      value_waddr   = slot_ff;
      value_re      = 1'b0;
      value_raddr   = cur_ff;
      link_we       = 1'b0;
      link_waddr    = '0;
      link_wdata    = '0;
      link_re       = 1'b0;
      link_raddr    = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in   = req_tuser;
               value_in  = req_tdata[31:0];
               pos_in    = req_tdata[38:32];
               status_in = ST_DONE;
               rdval_in  = '0;
               state_in  = S_CHECK;
            end
         end
         S_CHECK: begin
            first_in = (p_eff == PW'(1));
            end_in   = (p_eff == cnt_p + PW'(1));
            steps_in = is_rd ? p_eff - PW'(1) : p_eff - PW'(2);
            state_in = S_DONE;
            if (is_ins) begin
               if (count_ff == CW'(CAPACITY)) begin
                  status_in = ST_FULL;
               end else if (p_eff == '0 || p_eff > cnt_p + PW'(1)) begin
                  status_in = ST_BADPOS;
               end else if (fresh_ff > count_ff) begin
                  link_re    = 1'b1;
                  link_raddr = free_ff;
                  state_in   = S_TAKE;
               end else begin
                  slot_in  = IW'(fresh_ff);
                  fresh_in = fresh_ff + CW'(1);
                  state_in = S_PLACE;
               end
            end else if (is_del || is_rd) begin
               if (count_ff == '0) begin
                  status_in = ST_EMPTY;
               end else if (p_eff == '0 || p_eff > cnt_p) begin
                  status_in = ST_BADPOS;
               end else begin
                  state_in = S_LOCATE;
               end
            end
         end
         S_TAKE: begin
            slot_in  = free_ff;
            free_in  = link_rd_ff;
            state_in = S_PLACE;
         end
         S_PLACE: begin
            value_we = 1'b1;
            link_we  = 1'b1;
            if (count_ff == '0) begin
               link_waddr = slot_ff;
               link_wdata = slot_ff;
               head_in    = slot_ff;
               tail_in    = slot_ff;
               count_in   = count_ff + CW'(1);
               state_in   = S_DONE;
            end else if (first_ff) begin
               link_waddr = slot_ff;
               link_wdata = head_ff;
               head_in    = slot_ff;
               state_in   = S_FIX;
            end else begin
               link_we    = 1'b0;
               link_re    = 1'b1;
               link_raddr = head_ff;
               cur_in     = head_ff;
               state_in   = S_WALK;
            end
         end
         S_FIX: begin
            link_we    = 1'b1;
            link_waddr = tail_ff;
            link_wdata = slot_ff;
            count_in   = count_ff + CW'(1);
            state_in   = S_DONE;
         end
         S_LOCATE: begin
            if (is_del && count_ff == CW'(1)) begin
               victim_in = head_ff;
               head_in   = '0;
               tail_in   = '0;
               state_in  = S_FREE;
            end else if (is_del && first_ff) begin
               victim_in  = head_ff;
               link_re    = 1'b1;
               link_raddr = head_ff;
               state_in   = S_DHEAD;
            end else begin
               link_re    = 1'b1;
               link_raddr = head_ff;
               cur_in     = head_ff;
               state_in   = S_WALK;
            end
         end
         S_WALK: begin
            if (steps_ff == '0) begin
               if (is_ins) begin
                  link_we    = 1'b1;
                  link_waddr = slot_ff;
                  link_wdata = link_rd_ff;
                  state_in   = S_LINK;
               end else if (is_rd) begin
                  value_re    = 1'b1;
                  value_raddr = cur_ff;
                  state_in    = S_RVAL;
               end else begin
                  victim_in  = link_rd_ff;
                  link_re    = 1'b1;
                  link_raddr = link_rd_ff;
                  state_in   = S_DLINK;
               end
            end else begin
               link_re    = 1'b1;
               link_raddr = link_rd_ff;
               cur_in     = link_rd_ff;
               steps_in   = steps_ff - PW'(1);
            end
         end
         S_LINK: begin
            link_we    = 1'b1;
            link_waddr = cur_ff;
            link_wdata = slot_ff;
            if (end_ff) begin
               tail_in = slot_ff;
            end
            count_in = count_ff + CW'(1);
            state_in = S_DONE;
         end
         S_RVAL: begin
            rdval_in = value_rd_ff;
            state_in = S_DONE;
         end
         S_DHEAD: begin
            head_in    = link_rd_ff;
            link_we    = 1'b1;
            link_waddr = tail_ff;
            link_wdata = link_rd_ff;
            state_in   = S_FREE;
         end
         S_DLINK: begin
            link_we    = 1'b1;
            link_waddr = cur_ff;
            link_wdata = link_rd_ff;
            if (victim_ff == tail_ff) begin
               tail_in = cur_ff;
            end
            state_in = S_FREE;
         end
         S_FREE: begin
            link_we    = 1'b1;
            link_waddr = victim_ff;
            link_wdata = free_ff;
            free_in    = victim_ff;
            count_in   = count_ff - CW'(1);
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_count_in  = COUNT_W'(count_ff);
               rsp_read_in   = rdval_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         free_ff      <= '0;
         count_ff     <= '0;
         fresh_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         free_ff      <= free_in;
         count_ff     <= count_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      value_ff      <= value_in;
      pos_ff        <= pos_in;
      slot_ff       <= slot_in;
      cur_ff        <= cur_in;
      victim_ff     <= victim_in;
      steps_ff      <= steps_in;
      first_ff      <= first_in;
      end_ff        <= end_in;
      status_ff     <= status_in;
      rdval_ff      <= rdval_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_read_ff   <= rsp_read_in;
   end

   always_ff @(posedge clock) begin
      if (value_we) begin
         value_mem[value_waddr] <= value_ff;
      end
      if (value_re) begin
         value_rd_ff <= value_mem[value_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      if (link_re) begin
         link_rd_ff <= link_mem[link_raddr];
      end
   end

endmodule

>>> rtl/core/pcl_checker.sv
// ----------------------------------------------------------------------------
// pcl_checker
// Port-level checks for the positional circular list, bound to its top level.
// ----------------------------------------------------------------------------
module pcl_checker #(
   parameter int unsigned CAPACITY = 64
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tvalid,
   input logic                 req_tready,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input pcl_pkg::status_type  rsp_tuser,
   input logic [39:0]          rsp_tdata
);
   import pcl_pkg::*;

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp word changed while stalled");

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp word valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $unsigned(rsp_tdata[6:0]) <= CAPACITY)
      else $error("element count beyond capacity");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_DONE |-> rsp_tdata[38:7] == '0)
      else $error("read value on a failed operation");

   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

endmodule

bind positional_circular_list_top pcl_checker #(.CAPACITY(CAPACITY)) u_pcl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata)
);

>>> dv/pcl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcl_scoreboard
// Watches the request and response channels of the positional circular list,
// keeps its own ordered list of values, works out the status, count and read
// value of every accepted request word and compares each response word
// against the oldest outstanding answer.
// ----------------------------------------------------------------------------
module pcl_scoreboard #(
   parameter int unsigned CAPACITY = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  pcl_pkg::kind_type      req_tuser,   // kind
   input  logic [39:0]            req_tdata,   // value[31:0], position[38:32]
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  pcl_pkg::status_type    rsp_tuser,   // status
   input  logic [39:0]            rsp_tdata,   // count[6:0], read_value[38:7]
   output int                     fail_count,
   output int                     pending
);
   import pcl_pkg::*;

   typedef struct packed {
      status_type           status;
      logic [COUNT_W-1:0]   count;
      logic [VALUE_W-1:0]   read_value;
   } answer_type;

   logic [VALUE_W-1:0] element_q[$];
   answer_type         answer_q[$];

   function automatic answer_type apply_op(kind_type kind, logic [VALUE_W-1:0] value,
                                           logic [POS_W-1:0] position);
      answer_type ans;
      int         len;
      int         pos;
      len            = element_q.size();
      ans.status     = ST_DONE;
      ans.read_value = '0;
      case (kind)
         K_INS_FRONT, K_INS_BACK, K_INS_AT: begin
            pos = (kind == K_INS_FRONT) ? 1 : (kind == K_INS_BACK) ? len + 1 : int'(position);
            if (len >= CAPACITY)
               ans.status = ST_FULL;
            else if (pos < 1 || pos > len + 1)
               ans.status = ST_BADPOS;
            else
               element_q.insert(pos - 1, value);
         end
         K_DEL_FRONT, K_DEL_BACK, K_DEL_AT, K_READ_AT: begin
            pos = (kind == K_DEL_FRONT) ? 1 : (kind == K_DEL_BACK) ? len : int'(position);
            if (len == 0)
               ans.status = ST_EMPTY;
            else if (pos < 1 || pos > len)
               ans.status = ST_BADPOS;
            else if (kind == K_READ_AT)
               ans.read_value = element_q[pos - 1];
            else
               element_q.delete(pos - 1);
         end
         default: ;
      endcase
      ans.count = COUNT_W'(element_q.size());
      return ans;
   endfunction

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         element_q.delete();
         answer_q.delete();
         fail_count = 0;
      end else begin
         if (req_tvalid && req_tready)
            answer_q.push_back(apply_op(req_tuser, req_tdata[31:0], req_tdata[38:32]));
         if (rsp_tvalid && rsp_tready) begin
            if (answer_q.size() == 0) begin
               $error("response word with no request outstanding");
               fail_count++;
            end else begin
               want = answer_q.pop_front();
               if (rsp_tuser !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tdata[6:0] !== want.count) begin
                  $error("count: expected %0d, got %0d", want.count, rsp_tdata[6:0]);
                  fail_count++;
               end
               if (rsp_tdata[38:7] !== want.read_value) begin
                  $error("read_value: expected %0d, got %0d",
                         $signed(want.read_value), $signed(rsp_tdata[38:7]));
                  fail_count++;
               end
            end
         end
      end
      pending = answer_q.size();
   end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the positional circular list: a directed pass over the empty,
// bad position and unused kind cases, then about 1100 random words in
// fill, mixed and drain stretches, under changing sender and receiver gaps
// and one long receiver stall. The scoreboard predicts and compares.
// ----------------------------------------------------------------------------
module tb;
   import pcl_pkg::*;

   localparam int unsigned CAPACITY  = 64;
   localparam int          N_RANDOM  = 1100;
   localparam int          CYCLE_CAP = 1000000;
   localparam int          STALL_LEN = 400;
   localparam int          DRAIN_LEN = 80;
   localparam kind_type    K_UNUSED  = kind_type'(3'd7);

   typedef enum int {MODE_FILL, MODE_MIX, MODE_DRAIN} mix_mode_type;

   logic          clock      = 1'b0;
   logic          reset      = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   kind_type      req_tuser  = K_INS_FRONT;
   logic [39:0]   req_tdata  = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   status_type    rsp_tuser;
   logic [39:0]   rsp_tdata;

   int            fail_count;
   int            pending;
   int            send_gap_pct = 25;
   int            recv_gap_pct = 61;
   int            list_len     = 0;
   int            cycles       = 0;
   bit            stall_go     = 1'b0;
   bit            stall_done   = 1'b0;

   positional_circular_list_top #(.CAPACITY(CAPACITY)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   pcl_scoreboard #(.CAPACITY(CAPACITY)) u_scoreboard (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_CAP) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // receiver: random backpressure, plus one long stall on request
   initial begin
      forever begin
         @(posedge clock);
         if (stall_go && !stall_done) begin
            stall_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (STALL_LEN) @(posedge clock);
         end else begin
            rsp_tready <= !reset && ($urandom_range(0, 99) >= recv_gap_pct);
         end
      end
   end

   task automatic push_op(kind_type kind, logic [31:0] value, logic [6:0] position);
      int pos;
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {1'b0, position, value};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // track the length only, to aim positions
      case (kind)
         K_INS_FRONT, K_INS_BACK, K_INS_AT: begin
            pos = (kind == K_INS_FRONT) ? 1 :
                  (kind == K_INS_BACK) ? list_len + 1 : int'(position);
            if (list_len < CAPACITY && pos >= 1 && pos <= list_len + 1)
               list_len++;
         end
         K_DEL_FRONT, K_DEL_BACK, K_DEL_AT: begin
            pos = (kind == K_DEL_FRONT) ? 1 :
                  (kind == K_DEL_BACK) ? list_len : int'(position);
            if (list_len > 0 && pos >= 1 && pos <= list_len)
               list_len--;
         end
         default: ;
      endcase
   endtask

   task automatic push_random(mix_mode_type mode);
      int          r;
      int          ins_pct;
      int          del_pct;
      kind_type    kind;
      logic [31:0] value;
      logic [6:0]  position;
      ins_pct = (mode == MODE_FILL) ? 80 : (mode == MODE_MIX) ? 40 : 10;
      del_pct = (mode == MODE_FILL) ? 5 : (mode == MODE_MIX) ? 30 : 70;
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 99) == 0)
         kind = K_UNUSED;
      else if (r < ins_pct)
         kind = kind_type'($urandom_range(K_INS_FRONT, K_INS_AT));
      else if (r < ins_pct + del_pct)
         kind = kind_type'($urandom_range(K_DEL_FRONT, K_DEL_AT));
      else
         kind = K_READ_AT;
      if ($urandom_range(0, 9) == 0)
         position = 7'($urandom_range(0, 65));
      else if (kind inside {K_INS_FRONT, K_INS_BACK, K_INS_AT})
         position = 7'($urandom_range(1, list_len + 1));
      else
         position = 7'($urandom_range(1, (list_len == 0) ? 1 : list_len));
      case ($urandom_range(0, 39))
         0:       value = 32'h8000_0000;
         1:       value = 32'h7fff_ffff;
         2:       value = 32'h0000_0000;
         3:       value = 32'hffff_ffff;
         default: value = $urandom;
      endcase
      push_op(kind, value, position);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty list
      push_op(K_READ_AT,   32'h0000_1234, 7'd1);
      push_op(K_DEL_FRONT, 32'h0000_0000, 7'd0);
      push_op(K_DEL_BACK,  32'h0000_0000, 7'd0);
      push_op(K_DEL_AT,    32'h0000_0000, 7'd1);
      push_op(K_INS_AT,    32'h0000_0005, 7'd0);
      push_op(K_INS_AT,    32'h0000_0005, 7'd2);
      // build MAX, -1, MIN, 0 then push 1 in front
      push_op(K_INS_FRONT, 32'h7fff_ffff, 7'd0);
      push_op(K_INS_BACK,  32'h8000_0000, 7'd0);
      push_op(K_INS_AT,    32'hffff_ffff, 7'd2);
      push_op(K_INS_AT,    32'h0000_0000, 7'd4);
      push_op(K_INS_AT,    32'h0000_0001, 7'd1);
      push_op(K_READ_AT,   32'h0000_0000, 7'd1);
      push_op(K_READ_AT,   32'h0000_0000, 7'd5);
      push_op(K_READ_AT,   32'h0000_0000, 7'd6);
      push_op(K_READ_AT,   32'h0000_0000, 7'd0);
      push_op(K_READ_AT,   32'hffff_ffff, 7'd127);
      push_op(K_DEL_AT,    32'h0000_0000, 7'd3);
      push_op(K_DEL_AT,    32'h0000_0000, 7'd0);
      push_op(K_DEL_AT,    32'h0000_0000, 7'd5);
      push_op(K_DEL_AT,    32'h0000_0000, 7'd4);
      push_op(K_DEL_BACK,  32'h0000_0000, 7'd0);
      push_op(K_UNUSED,    32'h5555_aaaa, 7'd3);
      push_op(K_DEL_FRONT, 32'h0000_0000, 7'd0);
      push_op(K_DEL_FRONT, 32'h0000_0000, 7'd0);
      push_op(K_INS_AT,    32'haaaa_5555, 7'd1);

      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == N_RANDOM / 3) begin
            send_gap_pct = 61;
            recv_gap_pct = 25;
         end else if (i == 2 * N_RANDOM / 3) begin
            send_gap_pct = 0;
            recv_gap_pct = 0;
         end
         if (i == 2 * N_RANDOM / 3 + 50)
            stall_go = 1'b1;
         push_random(mix_mode_type'((i / 100) % 3));
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_LEN) @(posedge clock);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
